/* src/rrts_pkg.sv */
// shared types and constants of the round-robin thread scheduler
package rrts_pkg;

	// stream word widths
	localparam int FUNC_W   = 2;
	localparam int SLOT_W   = 7;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 24;
	localparam int OUT_USED = STATUS_W + SLOT_W + 1 + SLOT_W;

	// state of one thread slot
	typedef enum logic [1:0] {
		ST_INVALID  = 2'd0,
		ST_ACTIVE   = 2'd1,
		ST_BLOCKED  = 2'd2,
		ST_FINISHED = 2'd3
	} slot_state_t;

	// scheduler events
	typedef enum logic [FUNC_W-1:0] {
		EV_CREATE = 2'd0,
		EV_YIELD  = 2'd1,
		EV_JOIN   = 2'd2,
		EV_EXIT   = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NO_FREE   = 2'd1,
		STS_NO_ACTIVE = 2'd2
	} status_t;

	// controller states
	typedef enum logic [3:0] {
		C_CLEAR,
		C_IDLE,
		C_DECODE,
		C_SCAN,
		C_J_RDCUR,
		C_J_RDTGT,
		C_J_WRTGT,
		C_X_RDCUR,
		C_X_RDJ,
		C_X_WRJ,
		C_DONE
	} ctrl_state_t;

	// read address selection
	typedef enum logic [1:0] {
		RD_CUR,
		RD_TGT,
		RD_JOIN,
		RD_SCAN
	} rd_sel_t;

	// write address and data selection
	typedef enum logic [2:0] {
		WR_CLEAR,
		WR_NEW,
		WR_BLOCK,
		WR_LINK,
		WR_FIN,
		WR_RESUME
	} wr_sel_t;

	// source of a new running slot
	typedef enum logic [1:0] {
		CUR_PICK,
		CUR_TGT,
		CUR_JOIN
	} cur_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic        load_in;
		logic        rd_en;
		rd_sel_t     rd_sel;
		logic        latch_cur;
		logic        wr_en;
		wr_sel_t     wr_sel;
		logic        clear_step;
		logic        scan_start;
		slot_state_t scan_want;
		logic        set_cur;
		cur_sel_t    cur_sel;
		logic        set_status;
		status_t     status;
		logic        set_new;
		logic        out_load;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		func_t func;
		logic  clear_last;
		logic  tgt_ok;
		logic  cur_active;
		logic  rd_active;
		logic  rd_jv;
		logic  scan_hit;
		logic  scan_miss;
		logic  out_free;
	} dp_sts_t;

endpackage

/* src/rrts_dp.sv */
// datapath: slot table memory, running slot, circular scan and result register
module rrts_dp #(
	parameter int THREAD_SLOTS = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rrts_pkg::ctrl_cmd_t          cmd,
	output rrts_pkg::dp_sts_t            sts,
	input  logic [rrts_pkg::FUNC_W-1:0]  in_func,
	input  logic [rrts_pkg::SLOT_W-1:0]  in_target,
	output logic                         m_valid,
	input  logic                         m_ready,
	output logic [rrts_pkg::OUT_W-1:0]   m_data
);
	import rrts_pkg::*;

	localparam int SW = $clog2(THREAD_SLOTS);
	localparam int CW = $clog2(THREAD_SLOTS + 1);

	typedef struct packed {
		slot_state_t   st;
		logic          jv;
		logic [SW-1:0] js;
	} entry_t;

	entry_t        mem_q [THREAD_SLOTS];
	entry_t        rd_q;
	entry_t        cur_e_q;
	entry_t        wr_data;
	logic [SW-1:0] wr_addr;
	logic [SW-1:0] rd_addr;
	logic          rd_issue;

	func_t             func_q;
	logic [SLOT_W-1:0] target_q;
	logic [SW-1:0]     tgt_idx;
	logic [SW-1:0]     cur_q;
	logic [SW-1:0]     before_q;
	logic [SW-1:0]     clr_idx_q;

	logic [SW-1:0] scan_idx_q;
	logic [CW-1:0] scan_cnt_q;
	slot_state_t   want_q;
	logic          chk_vld_s1;
	logic          chk_last_s1;
	logic [SW-1:0] chk_idx_s1;
	logic          scan_issue;
	logic          match;

	status_t           res_status_q;
	logic [SW-1:0]     res_new_q;
	logic              m_valid_q;
	logic [OUT_W-1:0]  m_data_q;

	// circular successor of a slot number
	function automatic logic [SW-1:0] nxt(input logic [SW-1:0] i);
		return (i == SW'(THREAD_SLOTS - 1)) ? '0 : i + SW'(1);
	endfunction

	assign tgt_idx = SW'(target_q);

	// read address and issue
	assign scan_issue = cmd.rd_en && (cmd.rd_sel == RD_SCAN) &&
		(scan_cnt_q != CW'(THREAD_SLOTS));
	assign rd_issue = cmd.rd_en && ((cmd.rd_sel != RD_SCAN) || scan_issue);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_CUR:  rd_addr = cur_q;
			RD_TGT:  rd_addr = tgt_idx;
			RD_JOIN: rd_addr = cur_e_q.js;
			RD_SCAN: rd_addr = scan_idx_q;
			default: rd_addr = cur_q;
		endcase
	end

	// write address and word
	always_comb begin
		wr_addr = cur_q;
		wr_data = '{st: ST_INVALID, jv: 1'b0, js: '0};
		unique case (cmd.wr_sel)
			WR_CLEAR: begin
				wr_addr = clr_idx_q;
				wr_data.st = (clr_idx_q == '0) ? ST_ACTIVE : ST_INVALID;
			end
			WR_NEW: begin
				wr_addr = chk_idx_s1;
				wr_data.st = ST_ACTIVE;
			end
			WR_BLOCK: begin
				wr_addr = cur_q;
				wr_data = '{st: ST_BLOCKED, jv: cur_e_q.jv, js: cur_e_q.js};
			end
			WR_LINK: begin
				wr_addr = tgt_idx;
				wr_data = '{st: ST_ACTIVE, jv: 1'b1, js: cur_q};
			end
			WR_FIN: begin
				wr_addr = cur_q;
				wr_data = '{st: ST_FINISHED, jv: 1'b0, js: rd_q.js};
			end
			WR_RESUME: begin
				wr_addr = cur_e_q.js;
				wr_data = '{st: ST_ACTIVE, jv: rd_q.jv, js: rd_q.js};
			end
			default: begin
				wr_addr = cur_q;
			end
		endcase
	end

	// slot table memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_issue) begin
			rd_q <= mem_q[rd_addr];
		end
		if (cmd.latch_cur) begin
			cur_e_q <= rd_q;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear_step) begin
			clr_idx_q <= nxt(clr_idx_q);
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= func_t'(in_func);
			target_q <= in_target;
			before_q <= cur_q;
		end
	end

	// running slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.set_cur) begin
			unique case (cmd.cur_sel)
				CUR_PICK: cur_q <= chk_idx_s1;
				CUR_TGT:  cur_q <= tgt_idx;
				CUR_JOIN: cur_q <= cur_e_q.js;
				default:  cur_q <= cur_q;
			endcase
		end
	end

	// circular scan, one slot read per cycle, compared in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			chk_vld_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_cnt_q <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_idx_q <= nxt(cur_q);
			want_q     <= cmd.scan_want;
		end else if (scan_issue) begin
			scan_idx_q  <= nxt(scan_idx_q);
			chk_idx_s1  <= scan_idx_q;
			chk_last_s1 <= (scan_cnt_q == CW'(THREAD_SLOTS - 1));
		end
	end

	assign match = (rd_q.st == want_q);

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_status_q <= STS_OK;
			res_new_q    <= '0;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= cmd.status;
			end
			if (cmd.set_new) begin
				res_new_q <= chk_idx_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= {(OUT_W - OUT_USED)'(0), SLOT_W'(res_new_q), (cur_q != before_q),
				SLOT_W'(cur_q), res_status_q};
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = m_data_q;

	// status to the controller
	always_comb begin
		sts.func       = func_q;
		sts.clear_last = (clr_idx_q == SW'(THREAD_SLOTS - 1));
		sts.tgt_ok     = (32'(target_q) < THREAD_SLOTS) && (tgt_idx != cur_q);
		sts.cur_active = (cur_e_q.st == ST_ACTIVE);
		sts.rd_active  = (rd_q.st == ST_ACTIVE);
		sts.rd_jv      = rd_q.jv;
		sts.scan_hit   = chk_vld_s1 && match;
		sts.scan_miss  = chk_vld_s1 && chk_last_s1 && !match;
		sts.out_free   = !m_valid_q || m_ready;
	end

endmodule

/* src/rrts_ctrl.sv */
// controller state machine sequencing table accesses for each event
module rrts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	input  rrts_pkg::dp_sts_t   sts,
	output rrts_pkg::ctrl_cmd_t cmd
);
	import rrts_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		unique case (state_q)
			// sweep the table to its reset contents
			C_CLEAR: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WR_CLEAR;
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = C_IDLE;
				end
			end
			C_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load_in = 1'b1;
					state_d     = C_DECODE;
				end
			end
			C_DECODE: begin
				unique case (sts.func)
					EV_CREATE: begin
						cmd.scan_start = 1'b1;
						cmd.scan_want  = ST_INVALID;
						state_d        = C_SCAN;
					end
					EV_YIELD: begin
						cmd.scan_start = 1'b1;
						cmd.scan_want  = ST_ACTIVE;
						state_d        = C_SCAN;
					end
					EV_JOIN: begin
						if (sts.tgt_ok) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_CUR;
							state_d    = C_J_RDCUR;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_NO_ACTIVE;
							state_d        = C_DONE;
						end
					end
					EV_EXIT: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_CUR;
						state_d    = C_X_RDCUR;
					end
					default: begin
						state_d = C_DONE;
					end
				endcase
			end
			// one slot per cycle until a match or the whole ring is seen
			C_SCAN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SCAN;
				if (sts.scan_hit) begin
					if (sts.func == EV_CREATE) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WR_NEW;
						cmd.set_new = 1'b1;
					end else begin
						cmd.set_cur = 1'b1;
						cmd.cur_sel = CUR_PICK;
					end
					state_d = C_DONE;
				end else if (sts.scan_miss) begin
					cmd.set_status = 1'b1;
					cmd.status     = (sts.func == EV_CREATE) ? STS_NO_FREE : STS_NO_ACTIVE;
					state_d        = C_DONE;
				end
			end
			// join: fetch running entry, then target entry
			C_J_RDCUR: begin
				cmd.latch_cur = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_TGT;
				state_d       = C_J_RDTGT;
			end
			C_J_RDTGT: begin
				if (sts.cur_active && sts.rd_active) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_BLOCK;
					state_d    = C_J_WRTGT;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = STS_NO_ACTIVE;
					state_d        = C_DONE;
				end
			end
			C_J_WRTGT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_LINK;
				cmd.set_cur = 1'b1;
				cmd.cur_sel = CUR_TGT;
				state_d     = C_DONE;
			end
			// exit: finish running slot, then resume joiner or scan
			C_X_RDCUR: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = WR_FIN;
				cmd.latch_cur = 1'b1;
				if (sts.rd_jv) begin
					state_d = C_X_RDJ;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_want  = ST_ACTIVE;
					state_d        = C_SCAN;
				end
			end
			C_X_RDJ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_JOIN;
				state_d    = C_X_WRJ;
			end
			C_X_WRJ: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_RESUME;
				cmd.set_cur = 1'b1;
				cmd.cur_sel = CUR_JOIN;
				state_d     = C_DONE;
			end
			// hand the result word to the output register
			C_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

endmodule

/* src/round_robin_thread_scheduler_top.sv */
// Round-robin thread scheduler keeping a table of THREAD_SLOTS thread slots in one
// on-chip memory. Each input word is one event (create, yield, join, exit) and
// gives exactly one result word. After reset a clearing pass writes every slot
// once, during which no event is taken. Create, yield and exit without a joiner
// scan the table circularly from the slot after the running one, one memory read
// per cycle, and the scan stops early at the first match; join and exit with a
// joiner instead read and write single slots one after another, as the slot
// table has a single read port. One event is in work at a time; the next one is
// accepted as soon as the previous result sits in the output register.
module round_robin_thread_scheduler_top #(
	parameter int THREAD_SLOTS = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// func [1:0], target [8:2], zero pad above
	input  logic [rrts_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status [1:0], running [8:2], switched [9], new_slot [16:10], zero pad above
	output logic [rrts_pkg::OUT_W-1:0] m_axis_tdata
);
	import rrts_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer
	rrts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// slot table and result path
	rrts_dp #(
		.THREAD_SLOTS (THREAD_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_func   (s_axis_tdata[FUNC_W-1:0]),
		.in_target (s_axis_tdata[FUNC_W+SLOT_W-1:FUNC_W]),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata)
	);

endmodule

/* bench/rrts_sched_checker.sv */
`timescale 1ns / 1ps
// result checker for the round-robin thread scheduler: predicts each result word and compares
module rrts_sched_checker #(
	parameter int THREAD_SLOTS = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	// func [1:0], target [8:2], zero pad above
	input  logic [rrts_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status [1:0], running [8:2], switched [9], new_slot [16:10], zero pad above
	input  logic [rrts_pkg::OUT_W-1:0] m_axis_tdata,
	output int                         mismatches,
	output int                         outstanding
);
	import rrts_pkg::*;

	localparam int RUN_LSB = STATUS_W;
	localparam int SW_BIT  = STATUS_W + SLOT_W;
	localparam int NEW_LSB = STATUS_W + SLOT_W + 1;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   running;
		logic                switched;
		logic [SLOT_W-1:0]   new_slot;
	} outcome_t;

	// own copy of the slot table
	slot_state_t slot_tab [THREAD_SLOTS];
	logic        joined [THREAD_SLOTS];
	int          joiner_of [THREAD_SLOTS];
	int          running_slot;

	outcome_t outcome_q [$];
	outcome_t want;
	int       fail_total = 0;
	int       queued = 0;
	int       word_idx = 0;

	assign mismatches  = fail_total;
	assign outstanding = queued;

	task automatic report_mismatch(string what);
		$display("mismatch at result word %0d: %s", word_idx, what);
		fail_total++;
	endtask

	// first slot after the running one in the wanted state, the running one last
	function automatic int find_after(slot_state_t wanted);
		int pos;
		for (int i = 1; i <= THREAD_SLOTS; i++) begin
			pos = (running_slot + i) % THREAD_SLOTS;
			if (slot_tab[pos] == wanted)
				return pos;
		end
		return THREAD_SLOTS;
	endfunction

	// applies one event to the table and gives the result word it should produce
	function automatic outcome_t next_outcome(func_t ev, int tgt);
		outcome_t res;
		int       prior;
		int       pick;
		res = '0;
		res.status = STS_OK;
		prior = running_slot;
		case (ev)
		EV_CREATE: begin
			pick = find_after(ST_INVALID);
			if (pick >= THREAD_SLOTS) begin
				res.status = STS_NO_FREE;
			end else begin
				slot_tab[pick] = ST_ACTIVE;
				joined[pick] = 1'b0;
				joiner_of[pick] = 0;
				res.new_slot = pick[SLOT_W-1:0];
			end
		end
		EV_YIELD: begin
			pick = find_after(ST_ACTIVE);
			if (pick >= THREAD_SLOTS)
				res.status = STS_NO_ACTIVE;
			else
				running_slot = pick;
		end
		EV_JOIN: begin
			if (tgt >= THREAD_SLOTS || tgt == running_slot || slot_tab[tgt] != ST_ACTIVE ||
					slot_tab[running_slot] != ST_ACTIVE) begin
				res.status = STS_NO_ACTIVE;
			end else begin
				slot_tab[running_slot] = ST_BLOCKED;
				joined[tgt] = 1'b1;
				joiner_of[tgt] = running_slot;
				running_slot = tgt;
			end
		end
		default: begin
			// exit: resume the joiner if there is one, otherwise pass on as a yield
			slot_tab[running_slot] = ST_FINISHED;
			if (joined[running_slot] && joiner_of[running_slot] < THREAD_SLOTS) begin
				pick = joiner_of[running_slot];
				joined[running_slot] = 1'b0;
				slot_tab[pick] = ST_ACTIVE;
				running_slot = pick;
			end else begin
				pick = find_after(ST_ACTIVE);
				if (pick >= THREAD_SLOTS)
					res.status = STS_NO_ACTIVE;
				else
					running_slot = pick;
			end
		end
		endcase
		res.running = running_slot[SLOT_W-1:0];
		res.switched = (running_slot != prior);
		return res;
	endfunction

	// predict on each accepted event word, compare on each accepted result word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				slot_tab[i] = ST_INVALID;
				joined[i] = 1'b0;
				joiner_of[i] = 0;
			end
			slot_tab[0] = ST_ACTIVE;
			running_slot = 0;
			outcome_q.delete();
			queued <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				outcome_q.push_back(next_outcome(func_t'(s_axis_tdata[FUNC_W-1:0]),
					int'(s_axis_tdata[FUNC_W +: SLOT_W])));
			if (m_axis_tvalid && m_axis_tready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("word %h with no event waiting", m_axis_tdata));
				end else begin
					want = outcome_q.pop_front();
					if (m_axis_tdata[STATUS_W-1:0] != want.status)
						report_mismatch($sformatf("status %0d, predicted %0d",
							m_axis_tdata[STATUS_W-1:0], want.status));
					if (m_axis_tdata[RUN_LSB +: SLOT_W] != want.running)
						report_mismatch($sformatf("running %0d, predicted %0d",
							m_axis_tdata[RUN_LSB +: SLOT_W], want.running));
					if (m_axis_tdata[SW_BIT] != want.switched)
						report_mismatch($sformatf("switched %0d, predicted %0d",
							m_axis_tdata[SW_BIT], want.switched));
					if (m_axis_tdata[NEW_LSB +: SLOT_W] != want.new_slot)
						report_mismatch($sformatf("new_slot %0d, predicted %0d",
							m_axis_tdata[NEW_LSB +: SLOT_W], want.new_slot));
					if (m_axis_tdata[OUT_W-1:OUT_USED] != '0)
						report_mismatch($sformatf("pad bits %h not zero",
							m_axis_tdata[OUT_W-1:OUT_USED]));
				end
				word_idx++;
			end
			queued <= outcome_q.size();
		end
	end

endmodule

/* bench/round_robin_thread_scheduler_top_tb.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the round-robin thread scheduler
module round_robin_thread_scheduler_top_tb;
	import rrts_pkg::*;

	localparam int THREAD_SLOTS = 128;
	localparam int EVENTS       = 1400;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 2000;
	localparam int NEW_LSB      = STATUS_W + SLOT_W + 1;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	int mismatches;
	int outstanding;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;
	int spawned [$];

	always #5 clk = ~clk;

	round_robin_thread_scheduler_top #(
		.THREAD_SLOTS(THREAD_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	rrts_sched_checker #(
		.THREAD_SLOTS(THREAD_SLOTS)
	) sched_chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// offer one event word after a random gap and hold it until taken
	task automatic post_event(func_t ev, logic [SLOT_W-1:0] tgt);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {{(IN_W - FUNC_W - SLOT_W){1'b0}}, tgt, ev};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	// stop offering until every predicted word has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side: random stalls per word, one long hold-off on request
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// note created slots as join targets, and watch for a stuck channel
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready && m_axis_tdata[NEW_LSB +: SLOT_W] != '0)
			spawned.push_back(int'(m_axis_tdata[NEW_LSB +: SLOT_W]));
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int    pick;
		int    tgt;
		func_t ev;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// yield with only slot 0 alive, then rejected joins on self and on an unused slot
		post_event(EV_YIELD, 7'h7F);
		post_event(EV_JOIN, 7'd0);
		post_event(EV_JOIN, 7'd127);
		post_event(EV_CREATE, 7'h55);
		post_event(EV_CREATE, 7'h2A);
		// join, then a second joiner on the same target replaces the first
		post_event(EV_JOIN, 7'd1);
		post_event(EV_YIELD, 7'd0);
		post_event(EV_JOIN, 7'd0);
		post_event(EV_JOIN, 7'd1);
		// exit hands back to the joiner, join on a finished slot is refused
		post_event(EV_EXIT, 7'h7F);
		post_event(EV_JOIN, 7'd1);
		post_event(EV_CREATE, 7'd0);
		// exit without a joiner, then with nothing left to run
		post_event(EV_EXIT, 7'd0);
		post_event(EV_EXIT, 7'h7F);
		post_event(EV_YIELD, 7'd0);
		// running slot finished: join refused until a yield moves on
		post_event(EV_CREATE, 7'h7F);
		post_event(EV_JOIN, 7'd4);
		post_event(EV_YIELD, 7'd0);
		post_event(EV_YIELD, 7'h7F);
		drain();

		// random mix, creates heavy enough to exhaust the free slots
		for (int n = 0; n < EVENTS; n++) begin
			no_gaps = (n >= 300 && n < 450);
			if (n == 600)
				hold_req = 1'b1;
			if (n == 900)
				drain();
			pick = $urandom_range(0, 99);
			tgt = $urandom_range(0, 127);
			if (pick < 12)
				ev = EV_CREATE;
			else if (pick < 52)
				ev = EV_YIELD;
			else if (pick < 93)
				ev = EV_JOIN;
			else
				ev = EV_EXIT;
			if (ev == EV_JOIN && spawned.size() != 0 && $urandom_range(0, 3) != 0)
				tgt = spawned[$urandom_range(0, spawned.size() - 1)];
			post_event(ev, tgt[SLOT_W-1:0]);
		end
		drain();
		repeat (THREAD_SLOTS + 10) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
src/rrts_pkg.sv
src/rrts_dp.sv
src/rrts_ctrl.sv
src/round_robin_thread_scheduler_top.sv
bench/rrts_sched_checker.sv
bench/round_robin_thread_scheduler_top_tb.sv
